[rtl/dupc_pkg.sv]
// Shared types, constants and the depth scaling function for the depth/user pixel colorizer.
// No dependencies; every other file in rtl imports this package.
package dupc_pkg;

    localparam int MAX_WIDTH  = 640;
    localparam int MAX_HEIGHT = 480;
    localparam int USER_SLOTS = 6;

    localparam int PIXEL_W    = 16;
    localparam int CHAN_W     = 16;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 9;
    localparam int INDEX_W    = 19;
    localparam int COUNT_W    = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_BINARY_MODE     = 3'd0;
    localparam cfg_addr_t REG_BINARY_INVERT   = 3'd1;
    localparam cfg_addr_t REG_GREY_MODE       = 3'd2;
    localparam cfg_addr_t REG_HIDE_BACKGROUND = 3'd3;
    localparam cfg_addr_t REG_MIRROR          = 3'd4;
    localparam cfg_addr_t REG_FRAME_WIDTH     = 3'd5;
    localparam cfg_addr_t REG_FRAME_HEIGHT    = 3'd6;

    localparam logic [COL_W-1:0] FRAME_WIDTH_RESET  = 10'd320;
    localparam logic [ROW_W-1:0] FRAME_HEIGHT_RESET = 9'd240;

    typedef logic [2:0] user_t;

    localparam user_t USER_NONE  = 3'd0;
    localparam user_t USER_1     = 3'd1;
    localparam user_t USER_2     = 3'd2;
    localparam user_t USER_3     = 3'd3;
    localparam user_t USER_4     = 3'd4;
    localparam user_t USER_5     = 3'd5;
    localparam user_t USER_6     = 3'd6;
    localparam user_t USER_EXTRA = 3'd7;

    localparam logic [12:0] DEPTH_DIV = 13'h0FFF;
    localparam logic [CHAN_W-1:0] CHAN_FULL = 16'hFFFF;

    typedef struct packed {
        logic             binary_mode;
        logic             binary_invert;
        logic             grey_mode;
        logic             hide_background;
        logic             mirror;
        logic [COL_W-1:0] frame_width;
        logic [ROW_W-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // 0xFFFF - (depth << 16) / 4095, low 16 bits.
    // depth << 16 = 4095 * x + x with x = depth << 4, so the quotient is x + x / 4095.
    function automatic logic [CHAN_W-1:0] depth_scale(input logic [PIXEL_W-1:0] raw);
        logic [12:0] dval;
        logic [16:0] x;
        logic [4:0]  est;
        logic [12:0] rem;
        logic [17:0] quo;
        dval = raw[15:3];
        x    = {dval, 4'b0000};
        est  = x[16:12];
        rem  = {1'b0, x[11:0]} + {8'b0, est};
        quo  = {1'b0, x} + {13'b0, est} + {17'b0, (rem >= DEPTH_DIV)};
        return CHAN_FULL - quo[15:0];
    endfunction

endpackage

[rtl/dupc_color.sv]
// Colour selection for one pixel: depth scaling, mode and user scheme, final inversion.
// Depends on dupc_pkg.
module dupc_color (
    input  logic [15:0]   raw_pixel,
    input  dupc_pkg::cfg_t cfg,
    output dupc_pkg::rgb_t color
);
    import dupc_pkg::*;

    user_t             user;
    logic              bg;
    logic [CHAN_W-1:0] d;
    logic [CHAN_W-1:0] d_half;
    logic [CHAN_W-1:0] d_quarter;
    logic [CHAN_W-1:0] fore;
    logic [CHAN_W-1:0] back;
    rgb_t              pre;

    assign user      = raw_pixel[2:0];
    assign bg        = (user == USER_NONE) || (user == USER_EXTRA);
    assign d         = depth_scale(raw_pixel);
    assign d_half    = d >> 1;
    assign d_quarter = d >> 2;
    assign fore      = cfg.binary_invert ? '0 : CHAN_FULL;
    assign back      = cfg.binary_invert ? CHAN_FULL : '0;

    always_comb begin
        pre = '0;
        if (cfg.binary_mode) begin
            pre.red = (bg && cfg.hide_background) ? back : fore;
            pre.green = pre.red;
            pre.blue = pre.red;
        end else if (cfg.grey_mode) begin
            pre.red = (bg && cfg.hide_background) ? '0 : d;
            pre.green = pre.red;
            pre.blue = pre.red;
        end else begin
            case (user)
                USER_NONE: begin
                    if (!cfg.hide_background) begin
                        pre.red = d_quarter;
                        pre.green = d_quarter;
                        pre.blue = d_quarter;
                    end
                end
                USER_1: pre.red = d;
                USER_2: begin
                    pre.red = d;
                    pre.green = d;
                end
                USER_3: begin
                    pre.red = d;
                    pre.blue = d;
                end
                USER_4: begin
                    pre.red = d;
                    pre.green = d_half;
                end
                USER_5: begin
                    pre.red = d;
                    pre.blue = d_half;
                end
                USER_6: begin
                    pre.red = d;
                    pre.green = d_half;
                    pre.blue = d_half;
                end
                default: begin
                    if (!cfg.hide_background) begin
                        pre.red = CHAN_FULL - d_half;
                        pre.green = pre.red;
                        pre.blue = pre.red;
                    end
                end
            endcase
        end
    end

    assign color.red   = ~pre.red;
    assign color.green = ~pre.green;
    assign color.blue  = ~pre.blue;

endmodule

[rtl/dupc_raster.sv]
// Raster position tracking: column, row and row base counters, destination index, frame end.
// Depends on dupc_pkg.
module dupc_raster (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dupc_pkg::cfg_t         cfg,
    input  logic                   advance,
    output logic [18:0]            dest_index,
    output logic                   frame_end
);
    import dupc_pkg::*;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [INDEX_W-1:0] base_reg, base_next;
    logic [COL_W-1:0]   w;
    logic [ROW_W-1:0]   h;
    logic [COL_W-1:0]   last_col;
    logic [COL_W-1:0]   col_held;
    logic [COL_W-1:0]   col_pos;
    logic               row_end;

    always_comb begin
        if (cfg.frame_width == '0) begin
            w = COL_W'(1);
        end else if (cfg.frame_width > COL_W'(MAX_WIDTH)) begin
            w = COL_W'(MAX_WIDTH);
        end else begin
            w = cfg.frame_width;
        end
        if (cfg.frame_height == '0) begin
            h = ROW_W'(1);
        end else if (cfg.frame_height > ROW_W'(MAX_HEIGHT)) begin
            h = ROW_W'(MAX_HEIGHT);
        end else begin
            h = cfg.frame_height;
        end
    end

    assign last_col   = w - COL_W'(1);
    assign col_held   = (col_reg < last_col) ? col_reg : last_col;
    assign col_pos    = cfg.mirror ? (last_col - col_held) : col_held;
    assign dest_index = base_reg + INDEX_W'(col_pos);
    assign row_end    = ({1'b0, col_reg} + (COL_W+1)'(1)) >= {1'b0, w};
    assign frame_end  = row_end && (({1'b0, row_reg} + (ROW_W+1)'(1)) >= {1'b0, h});

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (advance) begin
            if (frame_end) begin
                col_next  = '0;
                row_next  = '0;
                base_next = '0;
            end else if (row_end) begin
                col_next  = '0;
                row_next  = row_reg + ROW_W'(1);
                base_next = base_reg + INDEX_W'(w);
            end else begin
                col_next  = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

[rtl/dupc_users.sv]
// Sticky active-user flags for users 1 to 6 and their population count.
// Depends on dupc_pkg.
module dupc_users (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [2:0]  user,
    input  logic        advance,
    output logic [5:0]  active_users,
    output logic [2:0]  active_count
);
    import dupc_pkg::*;

    logic [USER_SLOTS-1:0] flags_reg, flags_next;
    logic [USER_SLOTS-1:0] seen;
    user_t                 slot;

    assign slot = user - USER_1;

    always_comb begin
        seen = '0;
        if (user != USER_NONE && user != USER_EXTRA) begin
            seen = USER_SLOTS'(1) << slot;
        end
    end

    assign flags_next   = flags_reg | seen;
    assign active_users = flags_next;

    always_comb begin
        active_count = '0;
        for (int k = 0; k < USER_SLOTS; k++) begin
            active_count = active_count + COUNT_W'(flags_next[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (advance) begin
            flags_reg <= flags_next;
        end
    end

endmodule

[rtl/depth_user_pixel_colorizer.sv]
// Depth/user pixel colorizer: input register, colour and position logic, result register.
// The input register holds an accepted transfer until the result register is free; it is then
// loaded there and presented on m_. Throughput: one pixel per cycle while m_ready is high,
// limited by the single input and single result register.
// Reset (aresetn low, synchronous): config to defaults, raster counters and user flags cleared.
// Depends on dupc_pkg, dupc_color, dupc_raster and dupc_users.
module depth_user_pixel_colorizer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [2:0]                  cfg_addr,
    input  logic [9:0]                  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [15:0]                 s_raw_pixel,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [15:0]                 m_red,
    output logic [15:0]                 m_green,
    output logic [15:0]                 m_blue,
    output logic [18:0]                 m_dest_index,
    output logic [5:0]                  m_active_users,
    output logic [2:0]                  m_active_count,
    output logic                        m_frame_end
);
    import dupc_pkg::*;

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    logic [PIXEL_W-1:0] pixel_reg;
    logic               out_valid_reg;
    rgb_t               color_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [USER_SLOTS-1:0] users_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               frame_end_reg;

    logic               advance;
    rgb_t               color;
    logic [INDEX_W-1:0] dest_index;
    logic               frame_end;
    logic [USER_SLOTS-1:0] active_users;
    logic [COUNT_W-1:0] active_count;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.binary_mode     <= 1'b0;
            cfg_reg.binary_invert   <= 1'b0;
            cfg_reg.grey_mode       <= 1'b0;
            cfg_reg.hide_background <= 1'b0;
            cfg_reg.mirror          <= 1'b0;
            cfg_reg.frame_width     <= FRAME_WIDTH_RESET;
            cfg_reg.frame_height    <= FRAME_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_BINARY_MODE:     cfg_reg.binary_mode     <= cfg_wr_data[0];
                REG_BINARY_INVERT:   cfg_reg.binary_invert   <= cfg_wr_data[0];
                REG_GREY_MODE:       cfg_reg.grey_mode       <= cfg_wr_data[0];
                REG_HIDE_BACKGROUND: cfg_reg.hide_background <= cfg_wr_data[0];
                REG_MIRROR:          cfg_reg.mirror          <= cfg_wr_data[0];
                REG_FRAME_WIDTH:     cfg_reg.frame_width     <= cfg_wr_data[COL_W-1:0];
                REG_FRAME_HEIGHT:    cfg_reg.frame_height    <= cfg_wr_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pixel_reg <= s_raw_pixel;
        end
    end

    dupc_color u_color (
        .raw_pixel (pixel_reg),
        .cfg       (cfg_reg),
        .color     (color)
    );

    dupc_raster u_raster (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .advance    (advance),
        .dest_index (dest_index),
        .frame_end  (frame_end)
    );

    dupc_users u_users (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .user         (pixel_reg[2:0]),
        .advance      (advance),
        .active_users (active_users),
        .active_count (active_count)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            color_reg     <= color;
            index_reg     <= dest_index;
            users_reg     <= active_users;
            count_reg     <= active_count;
            frame_end_reg <= frame_end;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_red          = color_reg.red;
    assign m_green        = color_reg.green;
    assign m_blue         = color_reg.blue;
    assign m_dest_index   = index_reg;
    assign m_active_users = users_reg;
    assign m_active_count = count_reg;
    assign m_frame_end    = frame_end_reg;

endmodule

[sim/depth_user_pixel_colorizer_test.sv]
// Testbench for depth_user_pixel_colorizer: directed and random pixel traffic on s_/m_ with
// an in-bench colour and raster predictor, random idling on both sides and config writes.
// Depends on dupc_pkg and the RTL top level only.
module depth_user_pixel_colorizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dupc_pkg::*;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int IDLE_PERCENT   = 27;
    localparam int SETTLE_CYCLES  = 4;
    localparam int STALL_LIMIT    = 1000;
    localparam int REPORT_LIMIT   = 200;
    localparam cfg_addr_t REG_SPARE = 3'd7;
    localparam logic [12:0] DEPTH_MIN = 13'd0;
    localparam logic [12:0] DEPTH_MAX = 13'h1FFF;

    typedef struct packed {
        logic [CHAN_W-1:0]     red;
        logic [CHAN_W-1:0]     green;
        logic [CHAN_W-1:0]     blue;
        logic [INDEX_W-1:0]    dest_index;
        logic [USER_SLOTS-1:0] active_users;
        logic [COUNT_W-1:0]    active_count;
        logic                  frame_end;
    } pixel_out_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [2:0]            cfg_addr;
    logic [9:0]            cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [15:0]           s_raw_pixel;
    logic                  m_valid;
    logic                  m_ready;
    logic [15:0]           m_red;
    logic [15:0]           m_green;
    logic [15:0]           m_blue;
    logic [18:0]           m_dest_index;
    logic [5:0]            m_active_users;
    logic [2:0]            m_active_count;
    logic                  m_frame_end;

    cfg_t                  shadow_cfg;
    logic [COL_W-1:0]      col_pos;
    logic [ROW_W-1:0]      row_pos;
    logic [INDEX_W-1:0]    row_start;
    logic [USER_SLOTS-1:0] users_seen;
    pixel_out_t            expected_pixels[$];
    int                    mismatches;
    bit                    no_idle;

    depth_user_pixel_colorizer u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_raw_pixel    (s_raw_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red          (m_red),
        .m_green        (m_green),
        .m_blue         (m_blue),
        .m_dest_index   (m_dest_index),
        .m_active_users (m_active_users),
        .m_active_count (m_active_count),
        .m_frame_end    (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned clamp_size(input int unsigned size, input int unsigned hi);
        if (size < 1) return 1;
        if (size > hi) return hi;
        return size;
    endfunction

    // Colour, position and user tracking for one pixel; advances the raster state.
    function automatic pixel_out_t colorize_pixel(input logic [15:0] raw);
        pixel_out_t    res;
        user_t         user;
        logic [31:0]   scaled;
        logic [15:0]   d;
        logic [15:0]   r;
        logic [15:0]   g;
        logic [15:0]   b;
        logic          bg;
        int unsigned   w;
        int unsigned   h;
        int unsigned   col;
        logic          row_end;
        logic          last_pixel;
        user = raw[2:0];
        scaled = 32'hFFFF - (32'h10000 * {19'd0, raw[15:3]}) / {19'd0, DEPTH_DIV};
        d = scaled[15:0];
        bg = (user == USER_NONE) || (user == USER_EXTRA);
        r = '0;
        g = '0;
        b = '0;
        if (!bg) users_seen[user - 3'd1] = 1'b1;
        if (shadow_cfg.binary_mode) begin
            if (bg && shadow_cfg.hide_background)
                r = shadow_cfg.binary_invert ? CHAN_FULL : 16'd0;
            else
                r = shadow_cfg.binary_invert ? 16'd0 : CHAN_FULL;
            g = r;
            b = r;
        end else if (shadow_cfg.grey_mode) begin
            r = (bg && shadow_cfg.hide_background) ? 16'd0 : d;
            g = r;
            b = r;
        end else begin
            case (user)
                USER_NONE: begin
                    if (!shadow_cfg.hide_background) begin
                        r = d >> 2;
                        g = r;
                        b = r;
                    end
                end
                USER_1: r = d;
                USER_2: begin
                    r = d;
                    g = d;
                end
                USER_3: begin
                    r = d;
                    b = d;
                end
                USER_4: begin
                    r = d;
                    g = d >> 1;
                end
                USER_5: begin
                    r = d;
                    b = d >> 1;
                end
                USER_6: begin
                    r = d;
                    g = d >> 1;
                    b = d >> 1;
                end
                default: begin
                    if (!shadow_cfg.hide_background) begin
                        r = CHAN_FULL - (d >> 1);
                        g = r;
                        b = r;
                    end
                end
            endcase
        end
        w = clamp_size(shadow_cfg.frame_width, MAX_WIDTH);
        h = clamp_size(shadow_cfg.frame_height, MAX_HEIGHT);
        col = (col_pos < w - 1) ? col_pos : w - 1;
        if (shadow_cfg.mirror) col = (w - 1) - col;
        row_end = (col_pos + 1 >= w);
        last_pixel = row_end && (row_pos + 1 >= h);
        res.red = CHAN_FULL - r;
        res.green = CHAN_FULL - g;
        res.blue = CHAN_FULL - b;
        res.dest_index = row_start + INDEX_W'(col);
        res.active_users = users_seen;
        res.active_count = COUNT_W'($countones(users_seen));
        res.frame_end = last_pixel;
        if (last_pixel) begin
            col_pos = '0;
            row_pos = '0;
            row_start = '0;
        end else if (row_end) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
            row_start = row_start + INDEX_W'(w);
        end else begin
            col_pos = col_pos + 1'b1;
        end
        return res;
    endfunction

    function automatic logic [15:0] pixel_of(input user_t user, input logic [12:0] depth);
        return {depth, user};
    endfunction

    function automatic logic [15:0] random_pixel();
        case ($urandom_range(9))
            0: return pixel_of(user_t'($urandom_range(7)), DEPTH_MIN);
            1: return pixel_of(user_t'($urandom_range(7)), DEPTH_MAX);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input cfg_addr_t addr, input logic [9:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wr_data <= data;
        case (addr)
            REG_BINARY_MODE:     shadow_cfg.binary_mode = data[0];
            REG_BINARY_INVERT:   shadow_cfg.binary_invert = data[0];
            REG_GREY_MODE:       shadow_cfg.grey_mode = data[0];
            REG_HIDE_BACKGROUND: shadow_cfg.hide_background = data[0];
            REG_MIRROR:          shadow_cfg.mirror = data[0];
            REG_FRAME_WIDTH:     shadow_cfg.frame_width = data;
            REG_FRAME_HEIGHT:    shadow_cfg.frame_height = data[8:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_frame(input logic [9:0] width, input logic [9:0] height,
                             input logic flip);
        write_reg(REG_FRAME_WIDTH, width);
        write_reg(REG_FRAME_HEIGHT, height);
        write_reg(REG_MIRROR, {9'd0, flip});
    endtask

    task automatic send_pixel(input logic [15:0] raw);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_raw_pixel <= raw;
        do @(posedge aclk); while (s_ready !== 1'b1);
        expected_pixels.insert(expected_pixels.size(), colorize_pixel(raw));
    endtask

    task automatic send_random(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    // Drop valid and drain every outstanding result before touching registers.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic test_default_colors();
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        for (int u = int'(USER_NONE); u <= int'(USER_EXTRA); u++)
            send_pixel(pixel_of(user_t'(u), 13'($urandom)));
    endtask

    task automatic test_hidden_background();
        settle();
        write_reg(REG_HIDE_BACKGROUND, 10'd1);
        send_pixel(pixel_of(USER_NONE, DEPTH_MAX));
        send_pixel(pixel_of(USER_EXTRA, DEPTH_MIN));
        send_pixel(pixel_of(USER_EXTRA, DEPTH_MAX));
        send_pixel(pixel_of(USER_6, 13'($urandom)));
    endtask

    task automatic test_binary_and_grey();
        settle();
        write_reg(REG_BINARY_MODE, 10'd1);
        send_pixel(pixel_of(USER_NONE, 13'($urandom)));
        send_pixel(pixel_of(USER_5, 13'($urandom)));
        settle();
        write_reg(REG_BINARY_INVERT, 10'd1);
        send_pixel(pixel_of(USER_EXTRA, 13'($urandom)));
        send_pixel(pixel_of(USER_2, 13'($urandom)));
        settle();
        write_reg(REG_HIDE_BACKGROUND, 10'd0);
        send_pixel(pixel_of(USER_NONE, 13'($urandom)));
        settle();
        write_reg(REG_BINARY_MODE, 10'd0);
        write_reg(REG_BINARY_INVERT, 10'd0);
        write_reg(REG_GREY_MODE, 10'd1);
        send_pixel(pixel_of(USER_EXTRA, DEPTH_MAX));
        send_pixel(pixel_of(USER_4, DEPTH_MIN));
        settle();
        write_reg(REG_HIDE_BACKGROUND, 10'd1);
        send_pixel(pixel_of(USER_NONE, 13'($urandom)));
        send_pixel(pixel_of(USER_1, 13'($urandom)));
        settle();
        write_reg(REG_GREY_MODE, 10'd0);
        write_reg(REG_HIDE_BACKGROUND, 10'd0);
    endtask

    task automatic test_frame_size_limits();
        settle();
        set_frame(10'd0, 10'd0, 1'b0);
        send_random(3);
        settle();
        set_frame(10'd1023, 10'd511, 1'b1);
        send_random(5);
        settle();
        set_frame(10'd640, 10'd1, 1'b1);
        send_random(4);
        settle();
        set_frame(10'd1, 10'd480, 1'b0);
        send_random(4);
        settle();
        set_frame(10'd3, 10'd2, 1'b1);
        send_random(12);
    endtask

    task automatic test_resize_mid_frame();
        settle();
        set_frame(10'd8, 10'd6, 1'b0);
        send_random(19);
        settle();
        set_frame(10'd2, 10'd2, 1'b0);
        send_random(6);
        settle();
        set_frame(10'd5, 10'd3, 1'b1);
        send_random(10);
    endtask

    task automatic test_random_traffic();
        int          sent;
        int          phase;
        int          count;
        logic [9:0]  width;
        logic [9:0]  height;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            no_idle = (phase >= 6) && (phase < 10);
            case ($urandom_range(9))
                0: width = 10'd0;
                1: width = 10'd1023;
                2: width = 10'd640;
                3: width = 10'($urandom);
                default: width = 10'($urandom_range(12, 1));
            endcase
            case ($urandom_range(9))
                0: height = {1'($urandom), 9'd0};
                1: height = {1'($urandom), 9'd511};
                2: height = {1'($urandom), 9'd480};
                3: height = 10'($urandom);
                default: height = {1'($urandom), 9'($urandom_range(6, 1))};
            endcase
            write_reg(REG_BINARY_MODE, {9'($urandom), 1'($urandom_range(99) < 30)});
            write_reg(REG_BINARY_INVERT, 10'($urandom));
            write_reg(REG_GREY_MODE, 10'($urandom));
            write_reg(REG_HIDE_BACKGROUND, 10'($urandom));
            write_reg(REG_MIRROR, 10'($urandom));
            write_reg(REG_FRAME_WIDTH, width);
            write_reg(REG_FRAME_HEIGHT, height);
            if ($urandom_range(7) == 0) write_reg(REG_SPARE, 10'($urandom));
            count = $urandom_range(60, 20);
            send_random(count);
            sent += count;
            phase++;
        end
        no_idle = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    task automatic compare_field(input string name, input logic [18:0] want,
                                 input logic [18:0] got);
        if (got !== want) begin
            if (mismatches < REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : check_output
        pixel_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_pixels.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("%0t: unexpected transfer, expected none, actual index %0h",
                             $time, m_dest_index);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("red", 19'(want.red), 19'(m_red));
                compare_field("green", 19'(want.green), 19'(m_green));
                compare_field("blue", 19'(want.blue), 19'(m_blue));
                compare_field("dest_index", want.dest_index, m_dest_index);
                compare_field("active_users", 19'(want.active_users), 19'(m_active_users));
                compare_field("active_count", 19'(want.active_count), 19'(m_active_count));
                compare_field("frame_end", 19'(want.frame_end), 19'(m_frame_end));
            end
        end
    end

    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en)
                stalled = 0;
            else
                stalled++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_raw_pixel = '0;
        m_ready = 1'b0;
        mismatches = 0;
        no_idle = 1'b0;
        shadow_cfg = '{binary_mode: 1'b0, binary_invert: 1'b0, grey_mode: 1'b0,
                       hide_background: 1'b0, mirror: 1'b0,
                       frame_width: FRAME_WIDTH_RESET, frame_height: FRAME_HEIGHT_RESET};
        col_pos = '0;
        row_pos = '0;
        row_start = '0;
        users_seen = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_colors();
        test_hidden_background();
        test_binary_and_grey();
        test_frame_size_limits();
        test_resize_mid_frame();
        test_random_traffic();

        settle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
